@@ hdl/rcpm_pkg.sv @@
// Shared types, constants and helper functions of the rounded corner pixel mask.
package rcpm_pkg;

  // Default for the largest frame dimension.
  localparam int MAX_DIM_DEFAULT = 4096;

  // Field and register widths.
  localparam int PIX_W      = 32;
  localparam int DIM_REG_W  = 13;
  localparam int PREF_W     = 2;
  localparam int DPI_W      = 10;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // The largest radius is 8 * 1023 / 96 = 85, which needs seven bits.
  localparam int RAD_W = 7;

  // Corner preference codes with a radius of their own.
  localparam logic [PREF_W-1:0] PREF_SQUARE = 2'd1;
  localparam logic [PREF_W-1:0] PREF_SMALL  = 2'd3;

  // Logical radii and the reference resolution.
  localparam int LOGICAL_SMALL = 4;
  localparam int LOGICAL_LARGE = 8;
  localparam int DPI_NOMINAL   = 96;

  // Reset values of the registers.
  localparam logic [DIM_REG_W-1:0] DIM_RESET  = 13'd1;
  localparam logic [PREF_W-1:0]    PREF_RESET = PREF_SQUARE;
  localparam logic [DPI_W-1:0]     DPI_RESET  = 10'(DPI_NOMINAL);

  // dpi * 8 / 96 equals dpi / 12; 683 / 2^13 approximates 1/12 closely enough
  // that the truncated product is exact for every ten-bit dpi.
  localparam int RECIP_12     = 683;
  localparam int RECIP_SHIFT  = 13;
  localparam int RECIP_PROD_W = DPI_W + 10;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CORNER_PREF  = 2'd2,
    REG_SCREEN_DPI   = 2'd3
  } cfg_reg_t;

  // Corner radius in device pixels for a preference and a dpi setting.
  function automatic logic [RAD_W-1:0] corner_radius(
    input logic [PREF_W-1:0] pref,
    input logic [DPI_W-1:0]  dpi
  );
    logic [DPI_W-1:0]        dpi_eff;
    logic [RECIP_PROD_W-1:0] prod;
    logic [RAD_W-1:0]        r_large;
    logic [RAD_W-1:0]        result;
    dpi_eff = (dpi == '0) ? DPI_W'(DPI_NOMINAL) : dpi;
    prod    = RECIP_PROD_W'(dpi_eff) * RECIP_PROD_W'(RECIP_12);
    r_large = RAD_W'(prod >> RECIP_SHIFT);
    case (pref)
      PREF_SQUARE: result = '0;
      PREF_SMALL:  result = r_large >> 1;
      default:     result = r_large;
    endcase
    return result;
  endfunction

endpackage

@@ hdl/rcpm_if.sv @@
// Stream interfaces for the pixel input and the masked pixel output.
interface rcpm_in_if;
  import rcpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface rcpm_out_if;
  import rcpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             was_cleared;
  logic             frame_last;

  modport source (output valid, output pixel_out, output was_cleared, output frame_last,
                  input ready);
  modport sink   (input valid, input pixel_out, input was_cleared, input frame_last,
                  output ready);
endinterface

@@ hdl/rounded_corner_pixel_mask_core.sv @@
// Rounded corner pixel mask: clears pixels outside the quarter circles in the frame corners.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------------
//  in_ch    | in        | valid / ready          | pixel_in[31:0]
//  out_ch   | out       | valid / ready          | pixel_out[31:0], was_cleared, frame_last
//  APB      | in        | psel, penable, pready  | paddr[3:0], pwdata / prdata [31:0]
//
// One transaction is accepted per clock unless the output stalls; each result passes
// through the position stage followed by the circle test stage.
// Reset sets width and height to 1, square corners, 96 dpi and both counters to zero.
// While out_ch.ready is low a full output register holds, and in_ch.ready falls only
// once the position stage is full as well. A width or height write restarts the frame.
module rounded_corner_pixel_mask_core #(
  parameter int MAX_DIMENSION = rcpm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rcpm_in_if.sink                          in_ch,
  rcpm_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rcpm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rcpm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rcpm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import rcpm_pkg::*;

  // Counter width covers positions up to MAX_DIMENSION-1, dimension width MAX_DIMENSION.
  localparam int CW   = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int DW   = $clog2(MAX_DIMENSION + 1);
  localparam int SQ_W = 2 * RAD_W + 2;

  // Dimension register value as used: zero counts as one, large values clamp.
  function automatic logic [DW-1:0] eff_dim(input logic [DIM_REG_W-1:0] v);
    logic [DW-1:0] d;
    if (v == '0) begin
      d = DW'(1);
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      d = DW'(MAX_DIMENSION);
    end else begin
      d = DW'(v);
    end
    return d;
  endfunction

  // Configuration registers and the radius derived from them.
  logic [DIM_REG_W-1:0] width_r, width_nxt;
  logic [DIM_REG_W-1:0] height_r, height_nxt;
  logic [PREF_W-1:0]    pref_r, pref_nxt;
  logic [DPI_W-1:0]     dpi_r, dpi_nxt;
  logic [RAD_W-1:0]     radius_r, radius_nxt;

  // Pixel position counters.
  logic [CW-1:0]        col_r, col_nxt;
  logic [CW-1:0]        row_r, row_nxt;

  // Position stage.
  logic                 s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]     s1_pixel_r;
  logic [RAD_W-1:0]     s1_dx_r;
  logic [RAD_W-1:0]     s1_dy_r;
  logic                 s1_corner_r;
  logic                 s1_last_r;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]     out_pixel_r;
  logic                 out_cleared_r;
  logic                 out_last_r;

  // Handshake and combinational terms.
  logic                 cfg_wr;
  cfg_reg_t             cfg_idx;
  logic                 out_free;
  logic                 in_acc;
  logic [DW-1:0]        w_eff;
  logic [DW-1:0]        h_eff;
  logic [CW-1:0]        w_m1;
  logic [CW-1:0]        h_m1;
  logic [CW-1:0]        col_rev;
  logic [CW-1:0]        row_rev;
  logic [CW-1:0]        dx_full;
  logic [CW-1:0]        dy_full;
  logic                 round_on;
  logic                 in_corner;
  logic                 at_last;
  logic [RAD_W:0]       a_term;
  logic [RAD_W:0]       b_term;
  logic [SQ_W-1:0]      a_sq;
  logic [SQ_W-1:0]      b_sq;
  logic [SQ_W:0]        dist_sum;
  logic [2*RAD_W-1:0]   r_sq;
  logic [SQ_W:0]        dist_lim;
  logic                 clear_pix;

  // APB decode; the port never waits.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_r);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_r);
      REG_CORNER_PREF:  prdata = APB_DATA_W'(pref_r);
      REG_SCREEN_DPI:   prdata = APB_DATA_W'(dpi_r);
      default:          prdata = '0;
    endcase
  end

  // Handshake: the position stage moves on whenever the output register is free.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Frame geometry from the dimension registers.
  assign w_eff = eff_dim(width_r);
  assign h_eff = eff_dim(height_r);
  assign w_m1  = CW'(w_eff - DW'(1));
  assign h_m1  = CW'(h_eff - DW'(1));

  // Distance to the nearest corner and the corner window test.
  assign col_rev   = w_m1 - col_r;
  assign row_rev   = h_m1 - row_r;
  assign dx_full   = (col_r < col_rev) ? col_r : col_rev;
  assign dy_full   = (row_r < row_rev) ? row_r : row_rev;
  assign round_on  = (radius_r != '0) &&
                     (32'(radius_r) <= 32'(w_eff >> 1)) &&
                     (32'(radius_r) <= 32'(h_eff >> 1));
  assign in_corner = round_on && (32'(dx_full) < 32'(radius_r)) &&
                     (32'(dy_full) < 32'(radius_r));
  assign at_last   = (col_r == w_m1) && (row_r == h_m1);

  // Circle test on doubled coordinates: (2r-2dx-1)^2 + (2r-2dy-1)^2 > 4r^2.
  assign a_term    = {radius_r, 1'b0} - {s1_dx_r, 1'b0} - (RAD_W + 1)'(1);
  assign b_term    = {radius_r, 1'b0} - {s1_dy_r, 1'b0} - (RAD_W + 1)'(1);
  assign a_sq      = SQ_W'(a_term) * SQ_W'(a_term);
  assign b_sq      = SQ_W'(b_term) * SQ_W'(b_term);
  assign dist_sum  = (SQ_W + 1)'(a_sq) + (SQ_W + 1)'(b_sq);
  assign r_sq      = (2 * RAD_W)'(radius_r) * (2 * RAD_W)'(radius_r);
  assign dist_lim  = (SQ_W + 1)'({r_sq, 2'b00});
  assign clear_pix = s1_corner_r && (dist_sum > dist_lim);

  // Next values of configuration, counters and valid flags.
  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    pref_nxt      = pref_r;
    dpi_nxt       = dpi_r;
    radius_nxt    = radius_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;

    // Advance the position on every accepted transaction.
    if (in_acc) begin
      if (col_r >= w_m1) begin
        col_nxt = '0;
        row_nxt = (row_r >= h_m1) ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end

    // Register writes; a dimension write restarts the frame.
    if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH: begin
          width_nxt = pwdata[DIM_REG_W-1:0];
          col_nxt   = '0;
          row_nxt   = '0;
        end
        REG_FRAME_HEIGHT: begin
          height_nxt = pwdata[DIM_REG_W-1:0];
          col_nxt    = '0;
          row_nxt    = '0;
        end
        REG_CORNER_PREF: begin
          pref_nxt   = pwdata[PREF_W-1:0];
          radius_nxt = corner_radius(pwdata[PREF_W-1:0], dpi_r);
        end
        REG_SCREEN_DPI: begin
          dpi_nxt    = pwdata[DPI_W-1:0];
          radius_nxt = corner_radius(pref_r, pwdata[DPI_W-1:0]);
        end
        default: begin
          width_nxt = width_r;
        end
      endcase
    end

    // Pipeline occupancy.
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DIM_RESET;
      height_r    <= DIM_RESET;
      pref_r      <= PREF_RESET;
      dpi_r       <= DPI_RESET;
      radius_r    <= corner_radius(PREF_RESET, DPI_RESET);
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      pref_r      <= pref_nxt;
      dpi_r       <= dpi_nxt;
      radius_r    <= radius_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r  <= in_ch.pixel_in;
      s1_dx_r     <= RAD_W'(dx_full);
      s1_dy_r     <= RAD_W'(dy_full);
      s1_corner_r <= in_corner;
      s1_last_r   <= at_last;
    end
    if (out_free && s1_valid_r) begin
      out_pixel_r   <= clear_pix ? '0 : s1_pixel_r;
      out_cleared_r <= clear_pix;
      out_last_r    <= s1_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_out   = out_pixel_r;
  assign out_ch.was_cleared = out_cleared_r;
  assign out_ch.frame_last  = out_last_r;

  // The position counters never leave the current frame.
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= w_m1) && (row_r <= h_m1))
    else $error("pixel position outside the frame");

  // The last pixel of a frame is followed by the first pixel of the next.
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && at_last |=> (col_r == '0) && (row_r == '0))
    else $error("counters did not wrap after the last pixel");

  // A cleared result always carries a zero pixel.
  a_cleared_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cleared_r |-> (out_pixel_r == '0))
    else $error("cleared pixel is not zero");

  // Masking only happens with an active radius.
  a_corner_radius: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_corner |-> (radius_r != '0))
    else $error("corner window flagged without a radius");

  // No input is taken while both stages are full and the output is held.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while both stages are blocked");

endmodule

@@ dv/rounded_corner_pixel_mask_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the rounded corner pixel mask core.
module rounded_corner_pixel_mask_core_tb;
  import rcpm_pkg::*;

  // Preference codes that select the large radius.
  localparam logic [PREF_W-1:0] PREF_LARGE     = 2'd0;
  localparam logic [PREF_W-1:0] PREF_LARGE_ALT = 2'd2;

  localparam int RESET_CYCLES  = 12;
  localparam int DRAIN_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_PIXELS = 1200;
  localparam int IDLE_PERCENT  = 29;

  // Expected result of one pixel.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             cleared;
    logic             last;
  } mask_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rcpm_in_if  in_ch ();
  rcpm_out_if out_ch ();

  // Shadow copy of the registers and the raster position.
  logic [DIM_REG_W-1:0] width_reg;
  logic [DIM_REG_W-1:0] height_reg;
  logic [PREF_W-1:0]    pref_reg;
  logic [DPI_W-1:0]     dpi_reg;
  logic [11:0]          col_pos;
  logic [11:0]          row_pos;

  mask_result_t expected_pixels[$];

  // When set, neither side inserts idle cycles.
  logic steady_flow = 1'b0;

  int unsigned error_count    = 0;
  int unsigned checked_count  = 0;
  int unsigned masked_count   = 0;
  int unsigned settings_count = 0;
  int unsigned random_sent    = 0;
  int unsigned cycle_count    = 0;

  rounded_corner_pixel_mask_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // A width or height of zero acts as one; values above the maximum are clamped.
  function automatic int unsigned eff_dimension(input logic [DIM_REG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return 32'(v);
  endfunction

  // Computes the masked pixel at the current raster position and advances it.
  function automatic mask_result_t predict_masked_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w, h, x, y, r, dpi, logical, dx, dy, a, b;
    mask_result_t res;
    w = eff_dimension(width_reg);
    h = eff_dimension(height_reg);
    x = 32'(col_pos);
    y = 32'(row_pos);
    r = 0;
    if (pref_reg != PREF_SQUARE) begin
      dpi     = (dpi_reg == '0) ? DPI_NOMINAL : 32'(dpi_reg);
      logical = (pref_reg == PREF_SMALL) ? LOGICAL_SMALL : LOGICAL_LARGE;
      r       = logical * dpi / DPI_NOMINAL;
    end
    res.pixel   = pix;
    res.cleared = 1'b0;
    // The circle test applies only when the radius fits in half of each dimension.
    if (r != 0 && r <= w / 2 && r <= h / 2) begin
      dx = (x < w - 1 - x) ? x : w - 1 - x;
      dy = (y < h - 1 - y) ? y : h - 1 - y;
      if (dx < r && dy < r) begin
        a = 2 * r - 2 * dx - 1;
        b = 2 * r - 2 * dy - 1;
        if (a * a + b * b > 4 * r * r) begin
          res.cleared = 1'b1;
          res.pixel   = '0;
        end
      end
    end
    res.last = (x == w - 1) && (y == h - 1);
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x[11:0];
    row_pos = y[11:0];
    return res;
  endfunction

  // Sends one pixel, with random idle cycles ahead of it, and records its result.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.pixel_in <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_pixels.push_back(predict_masked_pixel(pix));
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup phase, access phase until pready, then a return to idle.
  task automatic write_reg(input cfg_reg_t idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = val[DIM_REG_W-1:0];
        col_pos   = '0;
        row_pos   = '0;
      end
      REG_FRAME_HEIGHT: begin
        height_reg = val[DIM_REG_W-1:0];
        col_pos    = '0;
        row_pos    = '0;
      end
      REG_CORNER_PREF: pref_reg = val[PREF_W-1:0];
      default:         dpi_reg  = val[DPI_W-1:0];
    endcase
    @(posedge clk);
  endtask

  // Drains the pipeline and programs a full frame setting.
  task automatic set_frame(input int unsigned w, input int unsigned h,
                           input logic [PREF_W-1:0] pref, input int unsigned dpi);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_CORNER_PREF, APB_DATA_W'(pref));
    write_reg(REG_SCREEN_DPI, dpi);
    settings_count++;
  endtask

  // Reset values: a one-pixel frame with square corners, so every pixel ends a frame.
  task automatic test_reset_state();
    send_pixel('0);
    send_pixel('1);
    send_pixel(32'hA5A5_5A5A);
  endtask

  // A 4x4 frame with radius 2 clears exactly the four corner pixels.
  task automatic test_small_circle();
    set_frame(4, 4, PREF_LARGE, 24);
    for (int i = 0; i < 16; i++) begin
      send_pixel((i % 2 == 0) ? 32'hFFFF_FFFF : $urandom());
    end
  endtask

  // Radius 4 (zero dpi counts as nominal) does not fit in a width of 3.
  task automatic test_radius_too_large();
    set_frame(3, 8, PREF_SMALL, 0);
    repeat (3) send_pixel($urandom());
  endtask

  // A zero width acts as one and a height above the maximum is clamped.
  task automatic test_dimension_clamp();
    set_frame(0, 8191, PREF_LARGE_ALT, 1023);
    repeat (2) send_pixel($urandom());
  endtask

  // Largest radius over the top rows of a 170-wide frame, without any idling.
  task automatic test_max_radius();
    set_frame(170, 171, PREF_LARGE, 1023);
    steady_flow = 1'b1;
    repeat (340) send_pixel($urandom());
    random_sent += 340;
    wait_drained();
    steady_flow = 1'b0;
  endtask

  // Random frame settings, mostly small frames so that all four corners can be reached.
  task automatic test_random_frames(input int unsigned target);
    int unsigned w, h, dpi, count;
    logic [PREF_W-1:0] pref;
    while (random_sent < target) begin
      pref = PREF_W'($urandom_range(3));
      case ($urandom_range(3))
        0:       dpi = 0;
        1:       dpi = $urandom_range(12, 130);
        2:       dpi = DPI_NOMINAL;
        default: dpi = $urandom_range(1023);
      endcase
      if ($urandom_range(9) == 0) begin
        // Frame of any width up to 8191, clamped or not, with only a few pixels.
        case ($urandom_range(2))
          0:       w = MAX_DIM_DEFAULT;
          1:       w = $urandom_range(MAX_DIM_DEFAULT + 1, 8191);
          default: w = $urandom_range(1, MAX_DIM_DEFAULT);
        endcase
        h     = $urandom_range(0, 4);
        count = $urandom_range(1, 60);
      end else begin
        w     = $urandom_range(1, 20);
        h     = $urandom_range(1, 20);
        count = $urandom_range(1, 2 * w * h);
        if (count > 400) count = 400;
      end
      if (count > target - random_sent) count = target - random_sent;
      set_frame(w, h, pref, dpi);
      repeat (count) send_pixel($urandom());
      random_sent += count;
    end
  endtask

  // The result side stalls at random unless steady flow is requested.
  always @(posedge clk) begin
    out_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    mask_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result pixel_out=%h was_cleared=%b frame_last=%b",
                 $time, out_ch.pixel_out, out_ch.was_cleared, out_ch.frame_last);
        error_count++;
      end else begin
        exp_res = expected_pixels.pop_front();
        checked_count++;
        if (exp_res.cleared) masked_count++;
        if (out_ch.pixel_out !== exp_res.pixel) begin
          $display("%0t: pixel_out expected %h actual %h",
                   $time, exp_res.pixel, out_ch.pixel_out);
          error_count++;
        end
        if (out_ch.was_cleared !== exp_res.cleared) begin
          $display("%0t: was_cleared expected %b actual %b",
                   $time, exp_res.cleared, out_ch.was_cleared);
          error_count++;
        end
        if (out_ch.frame_last !== exp_res.last) begin
          $display("%0t: frame_last expected %b actual %b",
                   $time, exp_res.last, out_ch.frame_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_pixels.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.pixel_in <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    width_reg  = DIM_RESET;
    height_reg = DIM_RESET;
    pref_reg   = PREF_RESET;
    dpi_reg    = DPI_RESET;
    col_pos    = '0;
    row_pos    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_small_circle();
    test_radius_too_large();
    test_dimension_clamp();
    test_max_radius();
    test_random_frames(RANDOM_PIXELS);
    wait_drained();

    $display("Checked %0d pixels over %0d frame settings; %0d were masked to zero.",
             checked_count, settings_count, masked_count);
    $display("Settings included clamped sizes, zero and full-scale dpi and the largest radius.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
